FILE: src/gto_pkg.sv
`timescale 1ns / 1ps

package gto_pkg;

	// Graph size and derived widths
	localparam int NODES = 16;
	localparam int VTX_W = $clog2(NODES);
	localparam int PTR_W = VTX_W + 1;

	// Input function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_START = 1'b1;

	// Traversal mode codes
	localparam logic MODE_DFS = 1'b0;
	localparam logic MODE_BFS = 1'b1;

	// Register indexes on the configuration port
	localparam logic REG_MODE = 1'b0;

	typedef logic [NODES-1:0] row_t;
	typedef logic [VTX_W-1:0] vtx_t;
	typedef logic [PTR_W-1:0] ptr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_row;
		logic start;
		logic visit;
		logic descend;
		logic pop;
		logic fetch_top;
		logic fetch_head;
		logic flush;
	} gto_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic open_nz;
		logic stack_empty;
		logic queue_empty;
		logic slot_free;
	} gto_stat_t;

	// Index of the lowest set bit of a nonzero row
	function automatic vtx_t lowest_bit(input row_t w);
		vtx_t k;
		k = '0;
		for (int i = NODES - 1; i >= 0; i--) begin
			if (w[i]) begin
				k = VTX_W'(i);
			end
		end
		return k;
	endfunction

endpackage

FILE: src/gto_ctrl.sv
`timescale 1ns / 1ps

module gto_ctrl import gto_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      func,
	input  logic      mode,
	input  gto_stat_t stat,
	output logic      in_stall,
	output gto_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Take a new word only when idle
	assign in_stall = (state_q != ST_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (func == FUNC_LOAD) begin
						cmd.load_row = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (stat.open_nz) begin
					// visit the lowest open neighbor once the output slot frees
					if (stat.slot_free) begin
						cmd.visit   = 1'b1;
						cmd.descend = (mode == MODE_DFS);
					end
				end else begin
					cmd.pop = (mode == MODE_DFS);
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (mode == MODE_DFS) begin
					if (stat.stack_empty) begin
						state_d = ST_FLUSH;
					end else begin
						cmd.fetch_top = 1'b1;
						state_d       = ST_SCAN;
					end
				end else begin
					if (stat.queue_empty) begin
						state_d = ST_FLUSH;
					end else begin
						cmd.fetch_head = 1'b1;
						state_d        = ST_SCAN;
					end
				end
			end
			ST_FLUSH: begin
				// send the held vertex flagged as last
				if (stat.slot_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: src/gto_dpath.sv
`timescale 1ns / 1ps

module gto_dpath import gto_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  gto_cmd_t  cmd,
	input  vtx_t      row_index,
	input  row_t      row_bits,
	input  vtx_t      start_vertex,
	input  logic      out_stall,
	output gto_stat_t stat,
	output logic      out_valid,
	output vtx_t      vertex,
	output logic      last
);

	row_t adj_q [NODES];
	vtx_t pend_q [NODES];
	row_t visited_q;
	ptr_t head_q;
	ptr_t tail_q;
	vtx_t cur_q;
	vtx_t hold_q;
	logic out_valid_q;
	vtx_t out_vertex_q;
	logic out_last_q;

	row_t open_w;
	vtx_t next_w;
	ptr_t top_w;

	// Unvisited neighbors of the current vertex
	assign open_w = adj_q[cur_q] & ~visited_q;
	assign next_w = lowest_bit(open_w);
	assign top_w  = tail_q - ptr_t'(1);

	assign stat.open_nz     = |open_w;
	assign stat.stack_empty = (tail_q == '0);
	assign stat.queue_empty = (head_q == tail_q);
	assign stat.slot_free   = !out_valid_q || !out_stall;

	// Adjacency rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				adj_q[i] <= '0;
			end
		end else if (cmd.load_row) begin
			adj_q[row_index] <= row_bits;
		end
	end

	// Stack or queue storage
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pend_q[0] <= start_vertex;
		end else if (cmd.visit) begin
			pend_q[tail_q[VTX_W-1:0]] <= next_w;
		end
	end

	// Visited marks and pointers; the start vertex leaves the queue at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			head_q    <= '0;
			tail_q    <= '0;
		end else begin
			if (cmd.start) begin
				visited_q <= row_t'(1) << start_vertex;
				head_q    <= ptr_t'(1);
				tail_q    <= ptr_t'(1);
			end else if (cmd.visit) begin
				visited_q <= visited_q | (row_t'(1) << next_w);
				tail_q    <= tail_q + ptr_t'(1);
			end else if (cmd.pop) begin
				tail_q <= top_w;
			end else if (cmd.fetch_head) begin
				head_q <= head_q + ptr_t'(1);
			end
		end
	end

	// Current vertex and held result
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cur_q  <= start_vertex;
			hold_q <= start_vertex;
		end else begin
			if (cmd.visit) begin
				hold_q <= next_w;
			end
			if (cmd.visit && cmd.descend) begin
				cur_q <= next_w;
			end else if (cmd.fetch_top) begin
				cur_q <= pend_q[top_w[VTX_W-1:0]];
			end else if (cmd.fetch_head) begin
				cur_q <= pend_q[head_q[VTX_W-1:0]];
			end
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.visit || cmd.flush) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.visit || cmd.flush) begin
			out_vertex_q <= hold_q;
			out_last_q   <= cmd.flush;
		end
	end

	assign out_valid = out_valid_q;
	assign vertex    = out_vertex_q;
	assign last      = out_last_q;

endmodule

FILE: src/graph_traversal_order_unit.sv
`timescale 1ns / 1ps

// Graph traversal order unit over a 16-vertex adjacency bit matrix.
// Input channel (in_valid/in_stall): func 0 loads the row row_bits into
// adjacency row row_index and gives no output; func 1 starts a traversal
// at start_vertex. in_stall is high from a start until its last vertex has
// been handed to the output register, so one traversal runs at a time.
// Output channel (out_valid/out_stall): one word per visited vertex, in
// depth-first or breadth-first order (APB register 0, bit 0: 0 = DFS,
// 1 = BFS); last marks the final vertex. Each vertex is held one step so
// the flag can be set, then moved into the output register.
// During a traversal the unit visits each newly found vertex, scans the
// current vertex until no open neighbor is left, then fetches the next
// one from the stack or queue, and at the end flushes the held vertex.
// A stall on the output halts the scan; nothing is dropped or repeated.
// Reset clears the adjacency matrix, visited marks, pointers and the
// mode register, and leaves the output empty.

module graph_traversal_order_unit import gto_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [3:0]  row_index,
	input  logic [15:0] row_bits,
	input  logic [3:0]  start_vertex,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  vertex,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic      mode_q;
	gto_cmd_t  cmd;
	gto_stat_t stat;

	// Mode register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DFS;
		end else if (psel && penable && pwrite && (paddr[2] == REG_MODE)) begin
			mode_q <= pwdata[0];
		end
	end

	// Register readback
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_MODE: prdata[0] = mode_q;
			default:  prdata    = '0;
		endcase
	end

	assign pready = 1'b1;

	gto_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.mode     (mode_q),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	gto_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.row_index    (row_index),
		.row_bits     (row_bits),
		.start_vertex (start_vertex),
		.out_stall    (out_stall),
		.stat         (stat),
		.out_valid    (out_valid),
		.vertex       (vertex),
		.last         (last)
	);

endmodule
